// ===== hdl/lkv_pkg.sv =====
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] value;
  } rsp_t;

endpackage

// ===== hdl/lkv_store.sv =====
module lkv_store #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  lkv_pkg::req_t             req_i,
  input  logic [lkv_pkg::CAP_W-1:0] cap_i,
  output lkv_pkg::rsp_t             rsp_o
);

  localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int EC_W   = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

  logic [MAX_ENTRIES-1:0]          valid_q, valid_d;
  logic [RANK_W-1:0]               rank_q [MAX_ENTRIES];
  logic [RANK_W-1:0]               rank_d [MAX_ENTRIES];
  logic [OCC_W-1:0]                occ_q, occ_d;
  logic signed [lkv_pkg::DATA_W-1:0] key_q [MAX_ENTRIES];
  logic signed [lkv_pkg::DATA_W-1:0] val_q [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0]          match, victim, valid_mid, free, slot;
  logic                            hit, full, evict, insert, is_put;
  logic [RANK_W-1:0]               hit_rank, oldest_rank;
  logic [lkv_pkg::DATA_W-1:0]      rd_val;
  logic [EC_W-1:0]                 eff_cap;

  always_comb begin
    eff_cap = EC_W'(cap_i);
    if (eff_cap == '0) begin
      eff_cap = EC_W'(1);
    end else if (eff_cap > EC_W'(MAX_ENTRIES)) begin
      eff_cap = EC_W'(MAX_ENTRIES);
    end
  end

  // ranks of valid entries are always 0 .. occ-1, so the oldest is occ-1
  assign oldest_rank = RANK_W'(occ_q - OCC_W'(1));
  assign full        = (EC_W'(occ_q) >= eff_cap);
  assign is_put      = (req_i.op == lkv_pkg::OP_PUT);

  always_comb begin
    hit_rank = '0;
    rd_val   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == req_i.key);
      victim[i] = valid_q[i] && (rank_q[i] == oldest_rank);
      hit_rank  = hit_rank | (match[i] ? rank_q[i] : '0);
      rd_val    = rd_val | (match[i] ? val_q[i] : '0);
    end
  end

  assign hit       = |match;
  assign evict     = is_put && !hit && full;
  assign insert    = is_put && !hit;
  assign valid_mid = valid_q & ~(evict ? victim : '0);
  assign free      = ~valid_mid;
  assign slot      = free & (~free + MAX_ENTRIES'(1));

  assign rsp_o.hit   = hit;
  assign rsp_o.value = (!is_put && hit) ? rd_val : '0;

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (req_valid_i) begin
      if (hit) begin
        // promote: younger entries age by one
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (match[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end
      end else if (insert) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot[i]) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (valid_mid[i]) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end else begin
            valid_d[i] = 1'b0;
            rank_d[i]  = '0;
          end
        end
        if (!evict) begin
          occ_d = occ_q + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && is_put) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (match[i]) begin
          val_q[i] <= req_i.value;
        end else if (insert && slot[i]) begin
          key_q[i] <= req_i.key;
          val_q[i] <= req_i.value;
        end
      end
    end
  end

endmodule

// ===== hdl/lru_key_value_cache_top.sv =====
// An accepted item waits in the input register until it advances into the result register.
// Throughput: one item per cycle while the output is not stalled; the entry compare and the rank update
// finish in the cycle between the input register and the result register.
// Reset clears all entry valid bits, recency ranks and the occupancy count;
// the capacity register resets to 16. Entry keys and values are not reset.
module lru_key_value_cache_top #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic signed [lkv_pkg::DATA_W-1:0]  lookup_key_i,
  input  logic signed [lkv_pkg::DATA_W-1:0]  write_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic signed [lkv_pkg::DATA_W-1:0]  read_value_o
);

  logic [lkv_pkg::CAP_W-1:0] cap_q;
  logic                      in_valid_q, out_valid_q;
  lkv_pkg::req_t             req_q;
  lkv_pkg::rsp_t             rsp, rsp_q;
  logic                      advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkv_pkg::CAP_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.op    <= operation_i;
      req_q.key   <= lookup_key_i;
      req_q.value <= write_value_i;
    end
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  lkv_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(advance),
    .req_i      (req_q),
    .cap_i      (cap_q),
    .rsp_o      (rsp)
  );

  assign out_valid_o  = out_valid_q;
  assign hit_o        = rsp_q.hit;
  assign read_value_o = rsp_q.value;

endmodule

// ===== hdl/lkv_checker.sv =====
module lkv_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               hit_o,
  input logic signed [lkv_pkg::DATA_W-1:0]  read_value_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(read_value_o))
    else $error("stalled result changed");

  // a miss never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> read_value_o == '0)
    else $error("miss with nonzero value");

  // with no result pending the input side is always open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // a result appears only after an accepted item has passed the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an accepted item");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (.*);
